FILE: src/pal_pkg.sv
`default_nettype none
package pal_pkg;

    localparam logic [1:0] FUNC_ALLOC   = 2'd0;
    localparam logic [1:0] FUNC_FREE    = 2'd1;
    localparam logic [1:0] FUNC_RELEASE = 2'd2;
    localparam logic [1:0] FUNC_NOP     = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_PAGES  = 2'd1;
    localparam logic [1:0] ST_BAD_BOUND = 2'd2;
    localparam logic [1:0] ST_MULTI     = 2'd3;

    localparam logic [1:0] CFG_SLOTS    = 2'd0;
    localparam logic [1:0] CFG_LIMIT    = 2'd1;
    localparam logic [1:0] CFG_DEBUG    = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_OPEN_PUSH,
        S_ALLOC_RD,
        S_ALLOC_TAKE,
        S_REL_RD,
        S_REL_STEP
    } t_state;

    typedef struct packed {
        logic       clear;
        logic       latch;
        logic       do_free;
        logic       open_begin;
        logic       push;
        logic       rd_cur;
        logic       alloc_take;
        logic       rel_mark;
        logic       rel_step;
        logic       finish;
        logic [1:0] status;
    } t_cmd;

    typedef struct packed {
        logic [1:0] func;
        logic       head_null;
        logic       can_open;
        logic       free_bad;
        logic       free_dbl;
        logic       debug;
        logic       push_last;
        logic       cur_null;
        logic       clear_last;
    } t_stat;

endpackage
`default_nettype wire

FILE: src/pal_ram.sv
`default_nettype none
module pal_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: src/pal_ctrl.sv
`default_nettype none
module pal_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire pal_pkg::t_stat i_stat,
    output pal_pkg::t_cmd       o_cmd,
    output logic                o_busy
);
    pal_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= pal_pkg::S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_busy  = (r_state != pal_pkg::S_IDLE);
        case (r_state)
            pal_pkg::S_CLEAR: begin
                // slot-use memory clearing pass after reset
                o_cmd.clear = 1'b1;
                if (i_stat.clear_last) begin
                    n_state = pal_pkg::S_IDLE;
                end
            end
            pal_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.latch = 1'b1;
                    n_state     = pal_pkg::S_DISPATCH;
                end
            end
            pal_pkg::S_DISPATCH: begin
                case (i_stat.func)
                    pal_pkg::FUNC_ALLOC: begin
                        if (!i_stat.head_null) begin
                            n_state = pal_pkg::S_ALLOC_RD;
                        end else if (i_stat.can_open) begin
                            o_cmd.open_begin = 1'b1;
                            n_state          = pal_pkg::S_OPEN_PUSH;
                        end else begin
                            o_cmd.finish = 1'b1;
                            o_cmd.status = pal_pkg::ST_NO_PAGES;
                            n_state      = pal_pkg::S_IDLE;
                        end
                    end
                    pal_pkg::FUNC_FREE: begin
                        o_cmd.do_free = 1'b1;
                        o_cmd.finish  = 1'b1;
                        if (i_stat.debug && i_stat.free_bad) begin
                            o_cmd.status = pal_pkg::ST_BAD_BOUND;
                        end else if (i_stat.debug && i_stat.free_dbl) begin
                            o_cmd.status = pal_pkg::ST_MULTI;
                        end else begin
                            o_cmd.status = pal_pkg::ST_OK;
                        end
                        n_state = pal_pkg::S_IDLE;
                    end
                    pal_pkg::FUNC_RELEASE: begin
                        o_cmd.rel_mark = 1'b1;
                        n_state        = pal_pkg::S_REL_RD;
                    end
                    default: begin
                        o_cmd.finish = 1'b1;
                        n_state      = pal_pkg::S_IDLE;
                    end
                endcase
            end
            pal_pkg::S_OPEN_PUSH: begin
                o_cmd.push = 1'b1;
                if (i_stat.push_last) begin
                    n_state = pal_pkg::S_ALLOC_RD;
                end
            end
            pal_pkg::S_ALLOC_RD: begin
                n_state = pal_pkg::S_ALLOC_TAKE;
            end
            pal_pkg::S_ALLOC_TAKE: begin
                o_cmd.alloc_take = 1'b1;
                o_cmd.finish     = 1'b1;
                n_state          = pal_pkg::S_IDLE;
            end
            pal_pkg::S_REL_RD: begin
                o_cmd.rd_cur = 1'b1;
                if (i_stat.cur_null) begin
                    o_cmd.finish = 1'b1;
                    n_state      = pal_pkg::S_IDLE;
                end else begin
                    n_state = pal_pkg::S_REL_STEP;
                end
            end
            pal_pkg::S_REL_STEP: begin
                o_cmd.rel_step = 1'b1;
                n_state        = pal_pkg::S_REL_RD;
            end
            default: begin
                n_state = pal_pkg::S_IDLE;
            end
        endcase
    end
endmodule
`default_nettype wire

FILE: src/pal_datapath.sv
`default_nettype none
module pal_datapath #(
    parameter int MAX_PAGES = 16,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire pal_pkg::t_cmd i_cmd,
    output pal_pkg::t_stat     o_stat,
    input  wire logic          i_cfg_we,
    input  wire logic [1:0]    i_cfg_addr,
    input  wire logic [4:0]    i_cfg_data,
    input  wire logic [1:0]    i_func,
    input  wire logic [3:0]    i_page_index,
    input  wire logic [3:0]    i_slot_index,
    output logic               o_done,
    output logic [1:0]         o_status,
    output logic [3:0]         o_granted_page,
    output logic [3:0]         o_granted_slot,
    output logic [31:0]        o_alloc_number,
    output logic [4:0]         o_pages_released,
    output logic [8:0]         o_objects_in_use,
    output logic [8:0]         o_free_objects,
    output logic [4:0]         o_pages_in_use,
    output logic [8:0]         o_peak_objects
);
    localparam int PW    = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int SW    = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
    localparam int AW    = PW + SW;
    localparam int HW    = AW + 1;
    localparam int DEPTH = 1 << AW;
    localparam int CW    = $clog2(MAX_PAGES * MAX_SLOTS + 1);
    localparam int PCW   = $clog2(MAX_PAGES + 1);
    localparam int UW    = $clog2(MAX_SLOTS + 1);

    logic [4:0]           r_spp;
    logic [4:0]           r_plim;
    logic                 r_dbg;
    logic [1:0]           r_func;
    logic [3:0]           r_pg;
    logic [3:0]           r_sl;
    logic [HW-1:0]        r_head;
    logic [HW-1:0]        r_cur;
    logic [HW-1:0]        r_prev;
    logic [UW-1:0]        r_pg_used [MAX_PAGES];
    logic [AW-1:0]        r_clr;
    logic [MAX_PAGES-1:0] r_open;
    logic [MAX_PAGES-1:0] r_closing;
    logic [31:0]          r_alloc;
    logic [CW-1:0]        r_in_cnt;
    logic [CW-1:0]        r_free_cnt;
    logic [CW-1:0]        r_peak;
    logic [PCW-1:0]       r_open_cnt;
    logic [PW-1:0]        r_open_pg;
    logic [SW-1:0]        r_cnt;
    logic [1:0]           r_status;
    logic [3:0]           r_gpage;
    logic [3:0]           r_gslot;
    logic [31:0]          r_anum;
    logic [PCW-1:0]       r_released;
    logic                 r_done;

    int                   e_slots;
    int                   e_limit;
    logic [PW-1:0]        sel_pg;
    logic                 found;
    logic [MAX_PAGES-1:0] busy_pg;
    logic [MAX_PAGES-1:0] closing_now;
    logic [PCW-1:0]       close_cnt;
    logic [AW-1:0]        fh;
    logic                 free_bad;
    logic                 free_ok;
    logic                 cur_closing;
    logic [CW-1:0]        in_next;
    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [HW-1:0]        ram_wdata;
    logic [AW-1:0]        ram_raddr;
    logic [HW-1:0]        ram_rdata;
    logic                 use_we;
    logic [AW-1:0]        use_waddr;
    logic                 use_wdata;
    logic [AW-1:0]        use_raddr;
    logic                 use_rdata;

    always_comb begin
        e_slots = (r_spp == 5'd0) ? 1 :
                  ((int'(r_spp) > MAX_SLOTS) ? MAX_SLOTS : int'(r_spp));
        e_limit = (r_plim == 5'd0 || int'(r_plim) > MAX_PAGES) ? MAX_PAGES : int'(r_plim);
    end

    // lowest unused page frame
    always_comb begin
        sel_pg = '0;
        found  = 1'b0;
        for (int p = MAX_PAGES - 1; p >= 0; p--) begin
            if (!r_open[p]) begin
                sel_pg = PW'(p);
                found  = 1'b1;
            end
        end
    end

    // a page is busy while its count of slots in use is nonzero
    always_comb begin
        close_cnt = '0;
        for (int p = 0; p < MAX_PAGES; p++) begin
            busy_pg[p]     = (r_pg_used[p] != '0);
            closing_now[p] = r_open[p] & ~busy_pg[p];
            close_cnt      = close_cnt + PCW'(closing_now[p]);
        end
    end

    always_comb begin
        fh          = {PW'(r_pg), SW'(r_sl)};
        free_bad    = (int'(r_pg) >= MAX_PAGES) || (int'(r_sl) >= e_slots) ||
                      !r_open[PW'(r_pg)];
        free_ok     = !free_bad && use_rdata;
        cur_closing = r_closing[r_cur[AW-1:SW]];
        in_next     = r_in_cnt + CW'(1);
    end

    always_comb begin
        o_stat.func       = r_func;
        o_stat.head_null  = r_head[AW];
        o_stat.can_open   = found && (int'(r_open_cnt) + 1 <= e_limit);
        o_stat.free_bad   = free_bad;
        o_stat.free_dbl   = !free_bad && !use_rdata;
        o_stat.debug      = r_dbg;
        o_stat.push_last  = (int'(r_cnt) + 1 >= e_slots);
        o_stat.cur_null   = r_cur[AW];
        o_stat.clear_last = (r_clr == '1);
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = fh;
        ram_wdata = r_head;
        if (i_cmd.push) begin
            ram_we    = 1'b1;
            ram_waddr = {r_open_pg, r_cnt};
        end else if (i_cmd.do_free) begin
            ram_we = free_ok;
        end else if (i_cmd.rel_step) begin
            ram_we    = cur_closing && !r_prev[AW];
            ram_waddr = r_prev[AW-1:0];
            ram_wdata = ram_rdata;
        end
        ram_raddr = i_cmd.rd_cur ? r_cur[AW-1:0] : r_head[AW-1:0];
    end

    // slot-use bit is read at the accept edge so it is ready in dispatch
    always_comb begin
        use_we    = 1'b0;
        use_waddr = fh;
        use_wdata = 1'b0;
        if (i_cmd.clear) begin
            use_we    = 1'b1;
            use_waddr = r_clr;
        end else if (i_cmd.alloc_take) begin
            use_we    = 1'b1;
            use_waddr = r_head[AW-1:0];
            use_wdata = 1'b1;
        end else if (i_cmd.do_free) begin
            use_we = free_ok;
        end
        use_raddr = i_cmd.latch ? {PW'(i_page_index), SW'(i_slot_index)} : fh;
    end

    pal_ram #(
        .WIDTH(HW),
        .DEPTH(DEPTH)
    ) u_link_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    pal_ram #(
        .WIDTH(1),
        .DEPTH(DEPTH)
    ) u_use_ram (
        .i_clk  (i_clk),
        .i_we   (use_we),
        .i_waddr(use_waddr),
        .i_wdata(use_wdata),
        .i_raddr(use_raddr),
        .o_rdata(use_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_func     <= i_func;
            r_pg       <= i_page_index;
            r_sl       <= i_slot_index;
            r_gpage    <= '0;
            r_gslot    <= '0;
            r_anum     <= '0;
            r_released <= '0;
        end
        if (i_cmd.finish) begin
            r_status <= i_cmd.status;
        end
        if (i_cmd.alloc_take) begin
            r_gpage <= 4'(r_head[AW-1:SW]);
            r_gslot <= 4'(r_head[SW-1:0]);
            r_anum  <= r_alloc + 32'd1;
        end
        if (i_cmd.rel_mark) begin
            r_closing  <= closing_now;
            r_released <= close_cnt;
            r_cur      <= r_head;
            r_prev     <= {1'b1, AW'(0)};
        end
        if (i_cmd.rel_step) begin
            r_cur <= ram_rdata;
            if (!cur_closing) begin
                r_prev <= r_cur;
            end
        end
        if (i_cmd.open_begin) begin
            r_open_pg <= sel_pg;
            r_cnt     <= '0;
        end
        if (i_cmd.push) begin
            r_cnt <= r_cnt + SW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spp      <= 5'd4;
            r_plim     <= 5'd0;
            r_dbg      <= 1'b1;
            r_head     <= {1'b1, AW'(0)};
            r_pg_used  <= '{default: '0};
            r_clr      <= '0;
            r_open     <= '0;
            r_alloc    <= '0;
            r_in_cnt   <= '0;
            r_free_cnt <= '0;
            r_peak     <= '0;
            r_open_cnt <= '0;
            r_done     <= 1'b0;
        end else begin
            r_done <= i_cmd.finish;
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    pal_pkg::CFG_SLOTS: r_spp  <= i_cfg_data;
                    pal_pkg::CFG_LIMIT: r_plim <= i_cfg_data;
                    pal_pkg::CFG_DEBUG: r_dbg  <= i_cfg_data[0];
                    default: ;
                endcase
            end
            if (i_cmd.clear) begin
                r_clr <= r_clr + AW'(1);
            end
            if (i_cmd.open_begin) begin
                r_open[sel_pg] <= 1'b1;
                r_open_cnt     <= r_open_cnt + PCW'(1);
            end
            if (i_cmd.push) begin
                r_head     <= {1'b0, r_open_pg, r_cnt};
                r_free_cnt <= r_free_cnt + CW'(1);
            end
            if (i_cmd.alloc_take) begin
                r_head               <= ram_rdata;
                r_free_cnt           <= r_free_cnt - CW'(1);
                r_alloc              <= r_alloc + 32'd1;
                r_pg_used[r_head[AW-1:SW]] <= r_pg_used[r_head[AW-1:SW]] + UW'(1);
                r_in_cnt             <= in_next;
                if (in_next > r_peak) begin
                    r_peak <= in_next;
                end
            end
            if (i_cmd.do_free && free_ok) begin
                r_pg_used[fh[AW-1:SW]] <= r_pg_used[fh[AW-1:SW]] - UW'(1);
                r_head       <= {1'b0, fh};
                r_free_cnt   <= r_free_cnt + CW'(1);
                r_in_cnt     <= r_in_cnt - CW'(1);
            end
            if (i_cmd.rel_mark) begin
                r_open     <= r_open & ~closing_now;
                r_open_cnt <= r_open_cnt - close_cnt;
            end
            if (i_cmd.rel_step && cur_closing) begin
                if (r_prev[AW]) begin
                    r_head <= ram_rdata;
                end
                if (r_free_cnt != '0) begin
                    r_free_cnt <= r_free_cnt - CW'(1);
                end
            end
        end
    end

    assign o_done           = r_done;
    assign o_status         = r_status;
    assign o_granted_page   = r_gpage;
    assign o_granted_slot   = r_gslot;
    assign o_alloc_number   = r_anum;
    assign o_pages_released = 5'(r_released);
    assign o_objects_in_use = 9'(r_in_cnt);
    assign o_free_objects   = 9'(r_free_cnt);
    assign o_pages_in_use   = 5'(r_open_cnt);
    assign o_peak_objects   = 9'(r_peak);
endmodule
`default_nettype wire

FILE: src/paged_slot_allocator_unit.sv
// one request at a time; busy is high from the accept edge until the result strobe,
// a new word is taken in the strobe cycle, and results cannot be stalled
// free, no-op and no_pages finish in dispatch; allocate reads the list head, then takes it,
// after opening a page first when the list is empty (one link-ram write per slot)
// free-empty-pages marks idle pages, then walks the free list (link-ram read per list node)
// sync active-low reset empties pool and resets config; busy then holds to clear slot use
`default_nettype none
module paged_slot_allocator_unit #(
    parameter int MAX_PAGES = 16,
    parameter int MAX_SLOTS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_addr,
    input  wire logic [4:0]  i_cfg_data,
    input  wire logic [1:0]  i_func,
    input  wire logic [3:0]  i_page_index,
    input  wire logic [3:0]  i_slot_index,
    output logic             o_done,
    output logic [1:0]       o_status,
    output logic [3:0]       o_granted_page,
    output logic [3:0]       o_granted_slot,
    output logic [31:0]      o_alloc_number,
    output logic [4:0]       o_pages_released,
    output logic [8:0]       o_objects_in_use,
    output logic [8:0]       o_free_objects,
    output logic [4:0]       o_pages_in_use,
    output logic [8:0]       o_peak_objects
);
    pal_pkg::t_cmd  cmd;
    pal_pkg::t_stat stat;

    pal_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_stat (stat),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    pal_datapath #(
        .MAX_PAGES(MAX_PAGES),
        .MAX_SLOTS(MAX_SLOTS)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_stat          (stat),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data),
        .i_func          (i_func),
        .i_page_index    (i_page_index),
        .i_slot_index    (i_slot_index),
        .o_done          (o_done),
        .o_status        (o_status),
        .o_granted_page  (o_granted_page),
        .o_granted_slot  (o_granted_slot),
        .o_alloc_number  (o_alloc_number),
        .o_pages_released(o_pages_released),
        .o_objects_in_use(o_objects_in_use),
        .o_free_objects  (o_free_objects),
        .o_pages_in_use  (o_pages_in_use),
        .o_peak_objects  (o_peak_objects)
    );
endmodule
`default_nettype wire

FILE: src/pal_checker.sv
`default_nettype none
module pal_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        o_done,
    input wire logic [1:0]  o_status,
    input wire logic [31:0] o_alloc_number
);
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy |=> busy) else $error("accepted word did not raise busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy) else $error("result strobe while busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("result strobe longer than one cycle");

    a_fail_no_number: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_status != pal_pkg::ST_OK |-> o_alloc_number == 32'd0)
        else $error("failed request reports an allocation number");
endmodule

bind paged_slot_allocator_unit pal_checker u_pal_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_done        (o_done),
    .o_status      (o_status),
    .o_alloc_number(o_alloc_number)
);
`default_nettype wire
